### rtl/pwrd_pkg.sv
// pwrd_pkg: window size, field widths and derived constants of the
// pulse window reversal detector; no dependencies
package pwrd_pkg;

    localparam int WINDOW   = 10;
    localparam int SAMPLE_W = 16;
    localparam int LIMIT_W  = 16;
    localparam int IDX_W    = $clog2(WINDOW);
    localparam int SUM_W    = SAMPLE_W + IDX_W;
    localparam int SQ_W     = 2 * SAMPLE_W + IDX_W;
    localparam int BOUND_W  = 2 * (LIMIT_W + 1);
    localparam int CMP_W    = (SQ_W > BOUND_W) ? SQ_W : BOUND_W;

    // mean = (sum * RECIP) >> RECIP_SHIFT, exact for every sum below 2**SUM_W
    localparam int RECIP_SHIFT = SUM_W + IDX_W;
    localparam int RECIP_W     = SUM_W + 2;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << RECIP_SHIFT) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_VAL[RECIP_W-1:0];

    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(longint'(WINDOW) * 65535);
    localparam logic [LIMIT_W-1:0] SPREAD_LIMIT_RESET = LIMIT_W'(20);

    typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

### rtl/pwrd_cell.sv
// pwrd_cell: one sample cell of the window chain, loads from its neighbor
// when shifted; depends on pwrd_pkg
module pwrd_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  pwrd_pkg::sample_t d_in,
    output pwrd_pkg::sample_t q
);
    import pwrd_pkg::*;

    sample_t value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (shift_en)
        begin
            value_reg <= d_in;
        end
    end

    assign q = value_reg;

endmodule

### rtl/pulse_window_reversal_detector.sv
// pulse_window_reversal_detector: top level, window chain of pwrd_cell,
// mean, spread and monotonic checks; depends on pwrd_pkg and pwrd_cell
//
// channel  | dir | tdata bits (lowest first)  | tuser
// s_axis   | in  | [15:0] sample              | none
// m_axis   | out | [0] reversal_flag, rest 0  | none
// cfg      | in  | [15:0] spread_limit        | none
//
// one transfer runs through the mean, quotient, walk, drain and done steps;
// the walk of the cell chain feeds one squarer per cycle
// the next sample is taken while a finished flag waits in the output register
// reset clears the window to zeros, the sum to zero and the limit to 20
// a stalled output holds the block in its last step until the flag is taken
module pulse_window_reversal_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] reversal_flag
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata       // [15:0] spread_limit
);
    import pwrd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAN,
        S_QUOT,
        S_WALK,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [PROD_W-1:0]    mprod_reg, mprod_next;
    logic [BOUND_W-1:0]   bound_reg, bound_next;
    sample_t              mean_reg, mean_next;
    sample_t              prev_reg, prev_next;
    logic [2*SAMPLE_W-1:0] dsq_reg, dsq_next;
    logic                 dsq_vld_reg, dsq_vld_next;
    logic [SQ_W-1:0]      sq_reg, sq_next;
    logic                 up_reg, up_next;
    logic                 dn_reg, dn_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic                 out_vld_reg, out_vld_next;
    logic                 out_flag_reg, out_flag_next;

    logic     in_xfer;
    logic     walking;
    logic     shift_en;
    sample_t  tail_in;
    sample_t  head;
    sample_t  diff;
    logic     flag;
    sample_t  cell_q [WINDOW];

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign walking  = (state_reg == S_WALK);
    assign shift_en = in_xfer || walking;
    assign tail_in  = walking ? cell_q[0] : s_axis_tdata[SAMPLE_W-1:0];
    assign head     = cell_q[0];

    // cell 0 is the oldest sample, cell WINDOW-1 the newest
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        sample_t d_in;
        if (i == WINDOW - 1)
        begin : g_tail
            assign d_in = tail_in;
        end
        else
        begin : g_body
            assign d_in = cell_q[i+1];
        end
        pwrd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .d_in     (d_in),
            .q        (cell_q[i])
        );
    end

    assign diff = (head >= mean_reg) ? (head - mean_reg) : (mean_reg - head);
    assign flag = (CMP_W'(sq_reg) >= CMP_W'(bound_reg)) && up_reg && dn_reg;

    always_comb
    begin
        state_next    = state_reg;
        limit_next    = cfg_we ? cfg_wdata : limit_reg;
        sum_next      = sum_reg;
        mprod_next    = mprod_reg;
        bound_next    = bound_reg;
        mean_next     = mean_reg;
        prev_next     = prev_reg;
        dsq_next      = dsq_reg;
        dsq_vld_next  = dsq_vld_reg;
        sq_next       = sq_reg;
        up_next       = up_reg;
        dn_next       = dn_reg;
        cnt_next      = cnt_reg;
        out_vld_next  = out_vld_reg;
        out_flag_next = out_flag_reg;

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    sum_next   = sum_reg - SUM_W'(head) + SUM_W'(s_axis_tdata);
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                mprod_next = PROD_W'(sum_reg) * PROD_W'(RECIP);
                bound_next = BOUND_W'(limit_reg + 17'd1) * BOUND_W'(limit_reg + 17'd1);
                state_next = S_QUOT;
            end
            S_QUOT:
            begin
                mean_next    = mprod_reg[RECIP_SHIFT +: SAMPLE_W];
                sq_next      = '0;
                dsq_vld_next = 1'b0;
                up_next      = 1'b0;
                dn_next      = 1'b0;
                cnt_next     = '0;
                state_next   = S_WALK;
            end
            S_WALK:
            begin
                dsq_next     = (2*SAMPLE_W)'(diff) * (2*SAMPLE_W)'(diff);
                dsq_vld_next = 1'b1;
                if (dsq_vld_reg)
                begin
                    sq_next = sq_reg + SQ_W'(dsq_reg);
                end
                if (cnt_reg != '0)
                begin
                    if (head > prev_reg)
                    begin
                        up_next = 1'b1;
                    end
                    if (head < prev_reg)
                    begin
                        dn_next = 1'b1;
                    end
                end
                prev_next = head;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(WINDOW - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                sq_next      = sq_reg + SQ_W'(dsq_reg);
                dsq_vld_next = 1'b0;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_flag_next = flag;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            limit_reg    <= SPREAD_LIMIT_RESET;
            sum_reg      <= '0;
            mprod_reg    <= '0;
            bound_reg    <= '0;
            mean_reg     <= '0;
            prev_reg     <= '0;
            dsq_reg      <= '0;
            dsq_vld_reg  <= 1'b0;
            sq_reg       <= '0;
            up_reg       <= 1'b0;
            dn_reg       <= 1'b0;
            cnt_reg      <= '0;
            out_vld_reg  <= 1'b0;
            out_flag_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            limit_reg    <= limit_next;
            sum_reg      <= sum_next;
            mprod_reg    <= mprod_next;
            bound_reg    <= bound_next;
            mean_reg     <= mean_next;
            prev_reg     <= prev_next;
            dsq_reg      <= dsq_next;
            dsq_vld_reg  <= dsq_vld_next;
            sq_reg       <= sq_next;
            up_reg       <= up_next;
            dn_reg       <= dn_next;
            cnt_reg      <= cnt_next;
            out_vld_reg  <= out_vld_next;
            out_flag_reg <= out_flag_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'd0, out_flag_reg};

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == S_MEAN)
        else $error("accepted sample did not start the mean step");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_MAX)
        else $error("running sum exceeds the window maximum");

    a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
        walking |-> cnt_reg <= IDX_W'(WINDOW - 1))
        else $error("walk counter past the window");

    a_flag_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == S_DONE))
        else $error("output loaded outside the final step");

endmodule
